>>> src/indexed_min_heap_event_queue_macros.svh
// Assertion macros for the indexed min-heap event queue checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef INDEXED_MIN_HEAP_EVENT_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_EVENT_QUEUE_MACROS_SVH

// same-cycle implication
`define IMHEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IMHEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/imheq_pkg.sv
// Shared constants, codes and types of the indexed min-heap event queue.
// No dependencies.
package imheq_pkg;

  localparam int EV_BITS       = 6;
  localparam int EV_COUNT      = 64;
  localparam int TIME_FIELD    = 48;
  localparam int IN_DATA_BITS  = 56;
  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 48;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_RESCH,
    S_LAST,
    S_CPAR,
    S_UP,
    S_UPCMP,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

>>> src/indexed_min_heap_event_queue.sv
// Top level of the indexed min-heap event queue: sequencer plus heap and
// position RAMs. Uses imheq_pkg, imheq_ram, imheq_ctrl.
//
//  channel  | direction | tdata (low bit up)                     | tuser
//  s_*      | in        | event_id, new_time                     | action
//  m_*      | out       | head_event, head_time, queue_empty,    | status
//           |           | head_changed, queued_count             |
//
// An item passes S_UP and S_UPCMP per level of a sift up and S_DN_L, S_DN_R and
// S_DN_CMP per level of a sift down, as the heap RAM has a single read port.
// Reset (rst, synchronous) empties the queue at once; no clearing pass.
// One item is in work at a time; a result waits in the output register while the
// next item is accepted, and m_tready low stalls only the end of that next item.
module indexed_min_heap_event_queue #(
  parameter int CAPACITY  = imheq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = imheq_pkg::TIME_BITS_DEF,
  localparam int SW       = $clog2(CAPACITY + 1),
  localparam int TW       = (TIME_BITS < imheq_pkg::TIME_FIELD) ? TIME_BITS
                                                                : imheq_pkg::TIME_FIELD,
  localparam int OUT_BITS = ((imheq_pkg::EV_BITS + imheq_pkg::TIME_FIELD + 2 + SW + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [imheq_pkg::IN_DATA_BITS-1:0] s_tdata,  // event_id, new_time
  input  logic [0:0]                         s_tuser,  // action
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [OUT_BITS-1:0]                m_tdata,  // head_event, head_time,
                                                       // queue_empty, head_changed,
                                                       // queued_count
  output logic [1:0]                         m_tuser   // status
);

  localparam int HW = imheq_pkg::EV_BITS + TW;

  logic                          heap_we, slot_we;
  logic [SW-1:0]                 heap_waddr, heap_raddr, slot_wdata, slot_rdata;
  logic [HW-1:0]                 heap_wdata, heap_rdata;
  logic [imheq_pkg::EV_BITS-1:0] slot_waddr, slot_raddr;

  imheq_ctrl #(.CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS)) u_ctrl (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .heap_we, .heap_waddr, .heap_wdata, .heap_raddr, .heap_rdata,
    .slot_we, .slot_waddr, .slot_wdata, .slot_raddr, .slot_rdata
  );

  imheq_ram #(.WIDTH(HW), .DEPTH(CAPACITY + 1)) u_heap_ram (
    .clk, .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  imheq_ram #(.WIDTH(SW), .DEPTH(imheq_pkg::EV_COUNT)) u_slot_ram (
    .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

endmodule

>>> src/imheq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module imheq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/imheq_ctrl.sv
// Sequencer of the event queue: lookup, sift up/down over the heap RAM,
// position table upkeep and the output register. Uses imheq_pkg.
module imheq_ctrl #(
  parameter int CAPACITY  = imheq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = imheq_pkg::TIME_BITS_DEF,
  localparam int SW       = $clog2(CAPACITY + 1),
  localparam int TW       = (TIME_BITS < imheq_pkg::TIME_FIELD) ? TIME_BITS
                                                                : imheq_pkg::TIME_FIELD,
  localparam int HW       = imheq_pkg::EV_BITS + TW,
  localparam int OUT_BITS = ((imheq_pkg::EV_BITS + imheq_pkg::TIME_FIELD + 2 + SW + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [imheq_pkg::IN_DATA_BITS-1:0] s_tdata,
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [OUT_BITS-1:0]               m_tdata,
  output logic [1:0]                        m_tuser,
  output logic                              heap_we,
  output logic [SW-1:0]                     heap_waddr,
  output logic [HW-1:0]                     heap_wdata,
  output logic [SW-1:0]                     heap_raddr,
  input  logic [HW-1:0]                     heap_rdata,
  output logic                              slot_we,
  output logic [imheq_pkg::EV_BITS-1:0]     slot_waddr,
  output logic [SW-1:0]                     slot_wdata,
  output logic [imheq_pkg::EV_BITS-1:0]     slot_raddr,
  input  logic [SW-1:0]                     slot_rdata
);

  localparam int EB = imheq_pkg::EV_BITS;

  imheq_pkg::state_t  state, state_next;
  imheq_pkg::status_t status, status_next;
  logic                act, act_next;
  logic [EB-1:0]       ev, ev_next;
  logic [SW-1:0]       fill, fill_next;
  logic [SW-1:0]       i, i_next;
  logic [EB-1:0]       cev, cev_next;
  logic [TW-1:0]       ct, ct_next;
  logic [EB-1:0]       kev, kev_next;
  logic [TW-1:0]       kt, kt_next;
  logic                has_r, has_r_next;
  logic                changed, changed_next;
  logic [EB-1:0]       head_ev, head_ev_next;
  logic [TW-1:0]       head_t, head_t_next;
  logic [imheq_pkg::EV_COUNT-1:0] ev_valid, ev_valid_next;
  logic                m_tvalid_next;
  logic [OUT_BITS-1:0] m_tdata_next;
  logic [1:0]          m_tuser_next;

  logic [EB-1:0] in_ev;
  logic [TW-1:0] in_t;
  logic [SW-1:0] s_raw, s_eff, par;
  logic [SW:0]   l_ext, r_ext, fill_ext;
  logic [TW-1:0] rd_time;
  logic [EB-1:0] rd_ev;
  logic          up_move, dn_move, take_r, out_free;

  assign in_ev    = s_tdata[EB-1:0];
  assign in_t     = s_tdata[EB +: TW];
  assign s_raw    = ev_valid[ev] ? slot_rdata : '0;
  assign s_eff    = (s_raw > fill) ? '0 : s_raw;
  assign par      = i >> 1;
  assign l_ext    = {i, 1'b0};
  assign r_ext    = l_ext + (SW+1)'(1);
  assign fill_ext = {1'b0, fill};
  assign rd_time  = heap_rdata[TW-1:0];
  assign rd_ev    = heap_rdata[HW-1 -: EB];
  assign up_move  = rd_time > ct;
  assign take_r   = has_r && !(kt < rd_time);
  assign dn_move  = has_r ? ((kt < ct) || (rd_time < ct)) : (kt < ct);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == imheq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      imheq_pkg::S_IDLE:   if (s_tvalid) state_next = imheq_pkg::S_LOOK;
      imheq_pkg::S_LOOK: begin
        if (!act) begin
          if (s_eff != '0)              state_next = imheq_pkg::S_RESCH;
          else if (fill >= SW'(CAPACITY)) state_next = imheq_pkg::S_DONE;
          else                           state_next = imheq_pkg::S_UP;
        end else begin
          if (s_eff == '0 || s_eff == fill) state_next = imheq_pkg::S_DONE;
          else                              state_next = imheq_pkg::S_LAST;
        end
      end
      imheq_pkg::S_RESCH:  state_next = (ct < rd_time) ? imheq_pkg::S_UP : imheq_pkg::S_DN_L;
      imheq_pkg::S_LAST:   state_next = (i > SW'(1)) ? imheq_pkg::S_CPAR : imheq_pkg::S_DN_L;
      imheq_pkg::S_CPAR:   state_next = (ct < rd_time) ? imheq_pkg::S_UP : imheq_pkg::S_DN_L;
      imheq_pkg::S_UP:     state_next = (i > SW'(1)) ? imheq_pkg::S_UPCMP : imheq_pkg::S_DONE;
      imheq_pkg::S_UPCMP:  state_next = up_move ? imheq_pkg::S_UP : imheq_pkg::S_DONE;
      imheq_pkg::S_DN_L:   state_next = (l_ext <= fill_ext) ? imheq_pkg::S_DN_R
                                                            : imheq_pkg::S_DONE;
      imheq_pkg::S_DN_R:   state_next = imheq_pkg::S_DN_CMP;
      imheq_pkg::S_DN_CMP: state_next = dn_move ? imheq_pkg::S_DN_L : imheq_pkg::S_DONE;
      imheq_pkg::S_DONE:   if (out_free) state_next = imheq_pkg::S_IDLE;
      default:             state_next = imheq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    act_next      = act;
    ev_next       = ev;
    fill_next     = fill;
    i_next        = i;
    cev_next      = cev;
    ct_next       = ct;
    kev_next      = kev;
    kt_next       = kt;
    has_r_next    = has_r;
    status_next   = status;
    changed_next  = changed;
    ev_valid_next = ev_valid;
    head_ev_next  = head_ev;
    head_t_next   = head_t;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    m_tuser_next  = m_tuser;
    heap_we       = 1'b0;
    heap_waddr    = i;
    heap_wdata    = {cev, ct};
    heap_raddr    = par;
    slot_we       = 1'b0;
    slot_waddr    = cev;
    slot_wdata    = i;
    slot_raddr    = ev;
    unique case (state)
      imheq_pkg::S_IDLE: begin
        slot_raddr = in_ev;
        if (s_tvalid) begin
          act_next     = s_tuser[0];
          ev_next      = in_ev;
          cev_next     = in_ev;
          ct_next      = in_t;
          status_next  = imheq_pkg::STAT_DONE;
          changed_next = 1'b0;
        end
      end
      imheq_pkg::S_LOOK: begin
        heap_raddr = s_eff;
        i_next     = s_eff;
        if (!act) begin
          if (s_eff == '0) begin
            if (fill >= SW'(CAPACITY)) begin
              status_next = imheq_pkg::STAT_FULL;
            end else begin
              fill_next = fill + SW'(1);
              i_next    = fill + SW'(1);
            end
          end
        end else if (s_eff == '0) begin
          status_next = imheq_pkg::STAT_IGNORED;
        end else begin
          ev_valid_next[ev] = 1'b0;
          fill_next         = fill - SW'(1);
          heap_raddr        = fill;
        end
      end
      imheq_pkg::S_LAST: begin
        cev_next = rd_ev;
        ct_next  = rd_time;
      end
      imheq_pkg::S_UP: begin
        heap_we = (i <= SW'(1));
      end
      imheq_pkg::S_UPCMP: begin
        heap_we = 1'b1;
        if (up_move) begin
          heap_wdata = heap_rdata;
          slot_waddr = rd_ev;
          i_next     = par;
        end
      end
      imheq_pkg::S_DN_L: begin
        heap_raddr = l_ext[SW-1:0];
        heap_we    = !(l_ext <= fill_ext);
      end
      imheq_pkg::S_DN_R: begin
        kev_next   = rd_ev;
        kt_next    = rd_time;
        has_r_next = (r_ext <= fill_ext);
        heap_raddr = r_ext[SW-1:0];
      end
      imheq_pkg::S_DN_CMP: begin
        heap_we = 1'b1;
        if (dn_move) begin
          heap_wdata = take_r ? heap_rdata : {kev, kt};
          slot_waddr = take_r ? rd_ev : kev;
          i_next     = take_r ? r_ext[SW-1:0] : l_ext[SW-1:0];
        end
      end
      imheq_pkg::S_DONE: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = '0;
          if (fill != '0) begin
            m_tdata_next[EB-1:0]                       = head_ev;
            m_tdata_next[EB +: imheq_pkg::TIME_FIELD]  = imheq_pkg::TIME_FIELD'(head_t);
          end
          m_tdata_next[EB + imheq_pkg::TIME_FIELD]     = (fill == '0);
          m_tdata_next[EB + imheq_pkg::TIME_FIELD + 1] = changed;
          m_tdata_next[EB + imheq_pkg::TIME_FIELD + 2 +: SW] = fill;
          m_tuser_next  = status;
        end
      end
      default: ;
    endcase
    slot_we = heap_we;
    if (heap_we) begin
      ev_valid_next[slot_waddr] = 1'b1;
      if (heap_waddr == SW'(1)) begin
        changed_next = 1'b1;
        head_ev_next = heap_wdata[HW-1 -: EB];
        head_t_next  = heap_wdata[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= imheq_pkg::S_IDLE;
      fill     <= '0;
      ev_valid <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      ev_valid <= ev_valid_next;
      m_tvalid <= m_tvalid_next;
    end
    act     <= act_next;
    ev      <= ev_next;
    i       <= i_next;
    cev     <= cev_next;
    ct      <= ct_next;
    kev     <= kev_next;
    kt      <= kt_next;
    has_r   <= has_r_next;
    status  <= status_next;
    changed <= changed_next;
    head_ev <= head_ev_next;
    head_t  <= head_t_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
  end

endmodule

>>> src/imheq_checker.sv
// Port-level checks of the event queue, bound to the top level.
// Uses imheq_pkg and indexed_min_heap_event_queue_macros.svh.
`include "indexed_min_heap_event_queue_macros.svh"

module imheq_checker #(
  parameter int CAPACITY  = imheq_pkg::CAPACITY_DEF,
  localparam int SW       = $clog2(CAPACITY + 1),
  localparam int OUT_BITS = ((imheq_pkg::EV_BITS + imheq_pkg::TIME_FIELD + 2 + SW + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_BITS-1:0] m_tdata,
  input logic [1:0]          m_tuser
);

  localparam int QE = imheq_pkg::EV_BITS + imheq_pkg::TIME_FIELD;

  logic          empty, changed;
  logic [SW-1:0] count;

  assign empty   = m_tdata[QE];
  assign changed = m_tdata[QE + 1];
  assign count   = m_tdata[QE + 2 +: SW];

  `IMHEQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `IMHEQ_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "item taken while busy")
  `IMHEQ_ASSERT_IMP(a_empty, m_tvalid && empty, count == '0 && m_tdata[imheq_pkg::EV_BITS-1:0] == '0, "empty queue shows a head")
  `IMHEQ_ASSERT_IMP(a_full, m_tvalid && m_tuser == imheq_pkg::STAT_FULL, count == SW'(CAPACITY), "drop below capacity")
  `IMHEQ_ASSERT_IMP(a_ignored, m_tvalid && m_tuser == imheq_pkg::STAT_IGNORED, !changed, "ignored cancel wrote root")

endmodule

bind indexed_min_heap_event_queue imheq_checker #(.CAPACITY(CAPACITY)) u_imheq_checker (.*);

>>> tb/sv/tb_indexed_min_heap_event_queue.sv
// Testbench for indexed_min_heap_event_queue: directed table then random
// schedule/cancel items, each result checked against an in-bench heap predictor.
// Depends on imheq_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_indexed_min_heap_event_queue;

  localparam int CAP = 64;
  localparam int OBITS = 64;
  localparam logic ACT_SCHED = 1'b0;
  localparam logic ACT_CANCEL = 1'b1;
  localparam longint LIMIT = 400000;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    imheq_pkg::status_t status;
    logic [5:0]  head_event;
    logic [47:0] head_time;
    logic        queue_empty;
    logic        head_changed;
    logic [6:0]  queued_count;
  } head_report_t;

  localparam int RB = $bits(head_report_t);

  typedef struct {
    logic        act;
    logic [5:0]  ev;
    logic [47:0] t;
    logic        known;
    head_report_t want;
  } drow_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic s_tready, m_tvalid;
  logic [55:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic [OBITS-1:0] m_tdata;
  logic [1:0] m_tuser;

  indexed_min_heap_event_queue uut (.*);

  always #2 clk = ~clk;

  logic [47:0] heap_time [1:CAP];
  logic [5:0]  heap_ev [1:CAP];
  int          pos_of [64];
  int          fill;
  head_report_t pending_heads[$];
  int errors = 0, n_sent = 0, n_got = 0, n_full = 0, n_ign = 0;
  longint cycles = 0;
  bit quiet_mode = 0;

  function automatic void put(int i, logic [5:0] e, logic [47:0] t);
    heap_time[i] = t; heap_ev[i] = e; pos_of[e] = i;
  endfunction

  function automatic int up(logic [5:0] e, logic [47:0] t, int i);
    while (i > 1 && heap_time[i/2] > t) begin
      put(i, heap_ev[i/2], heap_time[i/2]); i = i / 2;
    end
    put(i, e, t);
    return i;
  endfunction

  function automatic void down(logic [5:0] e, logic [47:0] t, int i);
    int l, n;
    forever begin
      l = 2 * i;
      if (l + 1 <= fill) begin
        if (!(heap_time[l] < t || heap_time[l+1] < t)) break;
        n = (heap_time[l] < heap_time[l+1]) ? l : l + 1;
      end else if (l <= fill) begin
        if (!(heap_time[l] < t)) break;
        n = l;
      end else break;
      put(i, heap_ev[n], heap_time[n]); i = n;
    end
    put(i, e, t);
  endfunction

  function automatic head_report_t predict_head(logic act, logic [5:0] e, logic [47:0] t);
    head_report_t r;
    int s, last;
    logic ch;
    r = '0; ch = 0;
    r.status = imheq_pkg::STAT_DONE;
    s = pos_of[e];
    if (s > fill) s = 0;
    if (act == ACT_SCHED) begin
      if (s != 0) begin
        if (t < heap_time[s]) ch = (up(e, t, s) == 1);
        else begin ch = (s == 1); down(e, t, s); end
      end else if (fill >= CAP) r.status = imheq_pkg::STAT_FULL;
      else begin fill++; ch = (up(e, t, fill) == 1); end
    end else if (s == 0) r.status = imheq_pkg::STAT_IGNORED;
    else begin
      last = fill; pos_of[e] = 0; fill--;
      if (s != last) begin
        if (s > 1 && heap_time[last] < heap_time[s/2])
          ch = (up(heap_ev[last], heap_time[last], s) == 1);
        else begin ch = (s == 1); down(heap_ev[last], heap_time[last], s); end
      end
    end
    if (fill != 0) begin r.head_event = heap_ev[1]; r.head_time = heap_time[1]; end
    else r.queue_empty = 1;
    r.head_changed = ch;
    r.queued_count = fill[6:0];
    return r;
  endfunction

  task automatic report(string what, logic [RB-1:0] got, logic [RB-1:0] want);
    errors++;
    $display("MISMATCH item %0d %s: got %0h want %0h", n_got, what, got, want);
  endtask

  task automatic send(logic act, logic [5:0] e, logic [47:0] t,
                      bit known = 0, head_report_t want = '0);
    head_report_t p;
    p = predict_head(act, e, t);
    if (known && p != want) report("table vs predictor", p, want);
    pending_heads.push_back(p);
    if (p.status == imheq_pkg::STAT_FULL) n_full++;
    if (p.status == imheq_pkg::STAT_IGNORED) n_ign++;
    while (!quiet_mode && $urandom_range(99) < 31) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tuser <= act; s_tdata <= {2'b00, t, e};
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) m_tready <= quiet_mode || ($urandom_range(99) >= 31);
    if (!rst && m_tvalid && m_tready) begin
      head_report_t g, w;
      g = '0;
      g.status = imheq_pkg::status_t'(m_tuser);
      g.head_event = m_tdata[5:0]; g.head_time = m_tdata[53:6];
      g.queue_empty = m_tdata[54]; g.head_changed = m_tdata[55];
      g.queued_count = m_tdata[62:56];
      n_got <= n_got + 1;
      if (pending_heads.size() == 0) report("unexpected result", g, '0);
      else begin
        w = pending_heads.pop_front();
        if (g.status != w.status) report("status", RB'(g.status), RB'(w.status));
        if (g.head_event != w.head_event)
          report("head_event", RB'(g.head_event), RB'(w.head_event));
        if (g.head_time != w.head_time)
          report("head_time", RB'(g.head_time), RB'(w.head_time));
        if (g.queue_empty != w.queue_empty)
          report("queue_empty", RB'(g.queue_empty), RB'(w.queue_empty));
        if (g.head_changed != w.head_changed)
          report("head_changed", RB'(g.head_changed), RB'(w.head_changed));
        if (g.queued_count != w.queued_count)
          report("queued_count", RB'(g.queued_count), RB'(w.queued_count));
      end
    end
    if (cycles > LIMIT) begin
      $display("indexed_min_heap_event_queue test failed");
      $finish;
    end
  end

  function automatic head_report_t hr(imheq_pkg::status_t st, int he, logic [47:0] ht,
                                      int em, int ch, int cnt);
    head_report_t r;
    r.status = st; r.head_event = 6'(he); r.head_time = ht; r.queue_empty = 1'(em);
    r.head_changed = 1'(ch); r.queued_count = 7'(cnt);
    return r;
  endfunction

  initial begin
    drow_t dtab[$];
    int k, e, roll;
    logic [47:0] t;
    for (k = 0; k < 64; k++) pos_of[k] = 0;
    fill = 0;
    dtab = '{
      '{ACT_CANCEL, 6'd5, 48'd0, 1, hr(imheq_pkg::STAT_IGNORED, 0, 0, 1, 0, 0)},
      '{ACT_SCHED, 6'd63, TMAX, 1, hr(imheq_pkg::STAT_DONE, 63, TMAX, 0, 1, 1)},
      '{ACT_SCHED, 6'd0, 48'd0, 1, hr(imheq_pkg::STAT_DONE, 0, 0, 0, 1, 2)},
      '{ACT_SCHED, 6'd7, 48'd0, 0, '0},
      '{ACT_SCHED, 6'd8, 48'd0, 0, '0},
      '{ACT_SCHED, 6'd9, 48'h10000, 0, '0},
      '{ACT_SCHED, 6'd0, 48'h20000, 0, '0},
      '{ACT_SCHED, 6'd9, 48'd1, 0, '0},
      '{ACT_CANCEL, 6'd63, 48'd0, 0, '0},
      '{ACT_CANCEL, 6'd7, TMAX, 0, '0},
      '{ACT_SCHED, 6'd42, 48'h5555_5555_5555, 0, '0},
      '{ACT_SCHED, 6'd21, 48'hAAAA_AAAA_AAAA, 0, '0},
      '{ACT_CANCEL, 6'd21, 48'd0, 0, '0},
      '{ACT_CANCEL, 6'd8, 48'd0, 0, '0},
      '{ACT_CANCEL, 6'd9, 48'd0, 0, '0},
      '{ACT_CANCEL, 6'd42, 48'd0, 0, '0},
      '{ACT_CANCEL, 6'd0, 48'd0, 0, '0},
      '{ACT_CANCEL, 6'd0, 48'd0, 1, hr(imheq_pkg::STAT_IGNORED, 0, 0, 1, 0, 0)}
    };
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dtab[i]) send(dtab[i].act, dtab[i].ev, dtab[i].t, dtab[i].known, dtab[i].want);
    for (k = 0; k < 64; k++) send(ACT_SCHED, k[5:0], 48'($urandom_range(255)));
    send(ACT_SCHED, 6'd3, 48'd7);
    send(ACT_SCHED, 6'd0, TMAX);
    for (k = 0; k < 1000; k++) begin
      quiet_mode = (k >= 400 && k < 520);
      e = $urandom_range(63);
      roll = $urandom_range(99);
      case ($urandom_range(3))
        0: t = 48'({$urandom, $urandom});
        1: t = 48'($urandom_range(15));
        2: t = heap_time[$urandom_range(1, fill > 0 ? fill : 1)];
        default: t = {2'($urandom_range(3)), 36'd0, 10'($urandom_range(1023))};
      endcase
      if (fill == 0 && roll >= 55) roll = 0;
      send(roll < 55 ? ACT_SCHED : ACT_CANCEL, e[5:0], t);
    end
    quiet_mode = 0;
    s_tvalid <= 0;
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d schedule/cancel items, checked %0d results", n_sent, n_got);
    $display("Full-queue drops %0d, ignored cancels %0d", n_full, n_ign);
    if (errors == 0 && pending_heads.size() == 0)
      $display("indexed_min_heap_event_queue test passed");
    else
      $display("indexed_min_heap_event_queue test failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/imheq_pkg.sv
src/imheq_ram.sv
src/imheq_ctrl.sv
src/indexed_min_heap_event_queue.sv
src/imheq_checker.sv
tb/sv/tb_indexed_min_heap_event_queue.sv
